[rtl/mma_pkg.sv]
package mma_pkg;

   // Array sizing.
   localparam int MAX_ROWS  = 16;
   localparam int MAX_INNER = 64;

   // Field widths.
   localparam int ROW_W      = 4;
   localparam int INNER_W    = 6;
   localparam int COL_W      = 12;
   localparam int ELEM_W     = 16;
   localparam int PROD_W     = 2 * ELEM_W;
   localparam int ACC_W      = 48;
   localparam int ROWS_CFG_W = 5;
   localparam int INNER_CFG_W = 7;

   // Configuration port.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_IN_USE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_IN_USE = 1'b1;

   localparam logic [ROWS_CFG_W-1:0]  ROWS_RESET  = ROWS_CFG_W'(MAX_ROWS);
   localparam logic [INNER_CFG_W-1:0] INNER_RESET = INNER_CFG_W'(MAX_INNER);

   // Request kinds.
   localparam logic REQ_WRITE_A  = 1'b0;
   localparam logic REQ_STREAM_B = 1'b1;

   // Control broadcast from the sequencer to every cell.
   typedef struct packed {
      logic                   wr_en;
      logic [ROW_W-1:0]       wr_row;
      logic                   rd_en;
      logic [INNER_W-1:0]     addr;
      logic [ELEM_W-1:0]      wdata;
      logic                   mul_en;
      logic [ELEM_W-1:0]      b_value;
      logic                   acc_en;
      logic [ROWS_CFG_W-1:0]  acc_rows;
      logic                   acc_last;
      logic                   shift_en;
   } mma_ctl_type;

endpackage

[rtl/mma_req_if.sv]
interface mma_req_if;
   logic                              valid;
   logic                              ready;
   logic                              req_type;
   logic [mma_pkg::ROW_W-1:0]         row_index;
   logic [mma_pkg::INNER_W-1:0]       inner_index;
   logic [mma_pkg::COL_W-1:0]         col_index;
   logic signed [mma_pkg::ELEM_W-1:0] elem_value;

   modport source (output valid, req_type, row_index, inner_index, col_index, elem_value,
                   input ready);
   modport sink   (input valid, req_type, row_index, inner_index, col_index, elem_value,
                   output ready);
endinterface

[rtl/mma_rsp_if.sv]
interface mma_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [mma_pkg::ROW_W-1:0]        c_row;
   logic [mma_pkg::COL_W-1:0]        c_col;
   logic signed [mma_pkg::ACC_W-1:0] c_value;
   logic                             last_of_column;

   modport source (output valid, c_row, c_col, c_value, last_of_column, input ready);
   modport sink   (input valid, c_row, c_col, c_value, last_of_column, output ready);
endinterface

[rtl/mma_cell.sv]
// One row of A, its multiplier and accumulator, and one stage of the result shift chain.
module mma_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [mma_pkg::ROW_W-1:0]      cell_row,
   input  mma_pkg::mma_ctl_type           ctl,
   input  logic [mma_pkg::ACC_W-1:0]      shift_in,
   output logic [mma_pkg::ACC_W-1:0]      shift_out
);

   logic [mma_pkg::ELEM_W-1:0]        a_mem [mma_pkg::MAX_INNER];
   logic signed [mma_pkg::ELEM_W-1:0] a_rd_ff;
   logic signed [mma_pkg::PROD_W-1:0] prod_ff;
   logic [mma_pkg::ACC_W-1:0]         acc_ff;
   logic [mma_pkg::ACC_W-1:0]         acc_in;
   logic [mma_pkg::ACC_W-1:0]         acc_sum;
   logic [mma_pkg::ACC_W-1:0]         out_ff;
   logic [mma_pkg::ACC_W-1:0]         out_in;
   logic                              row_used;

   always_ff @(posedge clock) begin
      if (ctl.wr_en && (ctl.wr_row == cell_row)) begin
         a_mem[ctl.addr] <= ctl.wdata;
      end
      if (ctl.rd_en) begin
         a_rd_ff <= a_mem[ctl.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= a_rd_ff * $signed(ctl.b_value);
      end
   end

   always_comb begin
      row_used = {1'b0, cell_row} < ctl.acc_rows;
      acc_sum  = acc_ff + {{(mma_pkg::ACC_W - mma_pkg::PROD_W){prod_ff[mma_pkg::PROD_W-1]}},
                           prod_ff};
      acc_in   = acc_ff;
      out_in   = out_ff;
      if (ctl.acc_en) begin
         if (row_used) begin
            acc_in = acc_sum;
         end
         if (ctl.acc_last) begin
            // The finished sum moves into the shift chain; the next column starts from zero.
            out_in = acc_in;
            acc_in = '0;
         end
      end else if (ctl.shift_en) begin
         out_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign shift_out = out_ff;

endmodule

[rtl/matrix_multiply_accumulate_core.sv]
// The B element that completes a column passes the multiplier and accumulator stages, and
// the first C result is then registered in the shift chain; the rest of the column
// follows one result per cycle while taken. Throughput: one element per cycle; a completing
// B element holds the input until its column is fully taken.
// Reset: synchronous, active high; clears accumulators and handshake state and restores
// sixteen rows and an inner length of sixty-four. The A store is undefined until written.
module matrix_multiply_accumulate_core (
   input  logic                                clock,
   input  logic                                reset,
   mma_req_if.sink                             req_ch,
   mma_rsp_if.source                           rsp_ch,
   input  logic                                csr_write_en,
   input  logic [mma_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mma_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // The CSRs keep the written value (rows: low five bits); clamped counts are derived.
   logic [mma_pkg::ROWS_CFG_W-1:0]  csr_rows_ff;
   logic [mma_pkg::INNER_CFG_W-1:0] csr_inner_ff;
   logic [mma_pkg::ROWS_CFG_W-1:0]  rows_eff;
   logic [mma_pkg::INNER_CFG_W-1:0] inner_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_rows_ff  <= mma_pkg::ROWS_RESET;
         csr_inner_ff <= mma_pkg::INNER_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            mma_pkg::CSR_ROWS_IN_USE: begin
               csr_rows_ff <= csr_wdata[mma_pkg::ROWS_CFG_W-1:0];
            end
            mma_pkg::CSR_INNER_IN_USE: begin
               csr_inner_ff <= csr_wdata[mma_pkg::INNER_CFG_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (csr_rows_ff == '0) begin
         rows_eff = mma_pkg::ROWS_CFG_W'(1);
      end else if (csr_rows_ff > mma_pkg::ROWS_RESET) begin
         rows_eff = mma_pkg::ROWS_RESET;
      end else begin
         rows_eff = csr_rows_ff;
      end
      if (csr_inner_ff == '0) begin
         inner_eff = mma_pkg::INNER_CFG_W'(1);
      end else if (csr_inner_ff > mma_pkg::INNER_RESET) begin
         inner_eff = mma_pkg::INNER_RESET;
      end else begin
         inner_eff = csr_inner_ff;
      end
   end

   // Input decode. Out-of-range elements are taken and dropped.
   logic req_xfer;
   logic in_range;
   logic a_write;
   logic b_go;
   logic b_last;

   assign req_xfer = req_ch.valid && req_ch.ready;
   assign in_range = {1'b0, req_ch.inner_index} < inner_eff;
   assign a_write  = req_xfer && (req_ch.req_type == mma_pkg::REQ_WRITE_A) && in_range
                     && ({1'b0, req_ch.row_index} < rows_eff);
   assign b_go     = req_xfer && (req_ch.req_type == mma_pkg::REQ_STREAM_B) && in_range;
   assign b_last   = b_go && ({1'b0, req_ch.inner_index} == (inner_eff - 1'b1));

   // B pipeline: stage one carries the element to the multipliers, stage two to the
   // accumulators. The row count of each element travels with it.
   logic                            s1_valid_ff;
   logic                            s1_last_ff;
   logic [mma_pkg::ELEM_W-1:0]      s1_b_ff;
   logic [mma_pkg::ROWS_CFG_W-1:0]  s1_rows_ff;
   logic [mma_pkg::COL_W-1:0]       s1_col_ff;
   logic                            s2_valid_ff;
   logic                            s2_last_ff;
   logic [mma_pkg::ROWS_CFG_W-1:0]  s2_rows_ff;
   logic [mma_pkg::COL_W-1:0]       s2_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= b_go;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_last_ff <= b_last;
      s1_b_ff    <= req_ch.elem_value;
      s1_rows_ff <= rows_eff;
      s1_col_ff  <= req_ch.col_index;
      s2_last_ff <= s1_last_ff;
      s2_rows_ff <= s1_rows_ff;
      s2_col_ff  <= s1_col_ff;
   end

   // Emission: the finished column sits in the cells' shift chain and moves one cell toward
   // row zero on every result transfer but the column's last.
   logic                            emit_ff;
   logic                            emit_in;
   logic [mma_pkg::ROW_W-1:0]       emit_row_ff;
   logic [mma_pkg::ROW_W-1:0]       emit_row_in;
   logic [mma_pkg::ROWS_CFG_W-1:0]  emit_rows_ff;
   logic [mma_pkg::COL_W-1:0]       emit_col_ff;
   logic                            hold_ff;
   logic                            hold_in;
   logic                            rsp_xfer;
   logic                            emit_last;
   logic                            col_done;

   assign col_done  = s2_valid_ff && s2_last_ff;
   assign rsp_xfer  = emit_ff && rsp_ch.ready;
   assign emit_last = {1'b0, emit_row_ff} == (emit_rows_ff - 1'b1);

   always_comb begin
      emit_in     = emit_ff;
      emit_row_in = emit_row_ff;
      hold_in     = hold_ff;
      if (b_last) begin
         hold_in = 1'b1;
      end
      if (rsp_xfer) begin
         if (emit_last) begin
            emit_in = 1'b0;
            hold_in = 1'b0;
         end else begin
            emit_row_in = emit_row_ff + 1'b1;
         end
      end
      if (col_done) begin
         emit_in     = 1'b1;
         emit_row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_ff     <= 1'b0;
         hold_ff     <= 1'b0;
         emit_row_ff <= '0;
      end else begin
         emit_ff     <= emit_in;
         hold_ff     <= hold_in;
         emit_row_ff <= emit_row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (col_done) begin
         emit_rows_ff <= s2_rows_ff;
         emit_col_ff  <= s2_col_ff;
      end
   end

   // Control broadcast to the row of cells.
   mma_pkg::mma_ctl_type ctl;

   always_comb begin
      ctl.wr_en    = a_write;
      ctl.wr_row   = req_ch.row_index;
      ctl.rd_en    = b_go;
      ctl.addr     = req_ch.inner_index;
      ctl.wdata    = req_ch.elem_value;
      ctl.mul_en   = s1_valid_ff;
      ctl.b_value  = s1_b_ff;
      ctl.acc_en   = s2_valid_ff;
      ctl.acc_rows = s2_rows_ff;
      ctl.acc_last = s2_last_ff;
      ctl.shift_en = rsp_xfer && !emit_last;
   end

   logic [mma_pkg::ACC_W-1:0] chain [mma_pkg::MAX_ROWS+1];

   assign chain[mma_pkg::MAX_ROWS] = '0;

   for (genvar gi = 0; gi < mma_pkg::MAX_ROWS; gi++) begin : g_cell
      mma_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_row  (mma_pkg::ROW_W'(gi)),
         .ctl       (ctl),
         .shift_in  (chain[gi+1]),
         .shift_out (chain[gi])
      );
   end

   assign req_ch.ready          = !hold_ff;
   assign rsp_ch.valid          = emit_ff;
   assign rsp_ch.c_row          = emit_row_ff;
   assign rsp_ch.c_col          = emit_col_ff;
   assign rsp_ch.c_value        = chain[0];
   assign rsp_ch.last_of_column = emit_last;

endmodule

[rtl/mma_checker.sv]
module mma_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [mma_pkg::ROW_W-1:0]    c_row,
   input logic [mma_pkg::COL_W-1:0]    c_col,
   input logic [mma_pkg::ACC_W-1:0]    c_value,
   input logic                         last_of_column
);

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(c_row) && $stable(c_col)
         && $stable(c_value) && $stable(last_of_column))
      else $error("stalled result changed");

   // Within a column, rows follow in order under one column number.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !last_of_column |=>
         rsp_valid && (c_row == $past(c_row) + 1'b1) && (c_col == $past(c_col)))
      else $error("column rows out of order");

   // The final row ends the column; no result follows in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && last_of_column |=> !rsp_valid)
      else $error("result after end of column");

   // Input is held while a column is being emitted.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input open during emission");

endmodule

bind matrix_multiply_accumulate_core mma_checker u_mma_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .c_row          (rsp_ch.c_row),
   .c_col          (rsp_ch.c_col),
   .c_value        (rsp_ch.c_value),
   .last_of_column (rsp_ch.last_of_column)
);
